FILE: rtl/core/dikeda_pkg.sv
// Shared types, constants and helper functions for the delayed Ikeda reservoir step.
`default_nettype none
package dikeda_pkg;

   localparam int unsigned FRAC_W  = 24;
   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE     = 3'd0,
      CSR_FEEDBACK_GAIN = 3'd1,
      CSR_DAMPING       = 3'd2,
      CSR_PHASE_OFFSET  = 3'd3,
      CSR_DRIVE_SCALING = 3'd4,
      CSR_DELAY_LENGTH  = 3'd5,
      CSR_MODE          = 3'd6
   } csr_index_type;

   localparam logic [31:0] TURN_K = 32'd2670177;
   localparam logic [17:0] DIV3_HI_K = 18'd174763;
   localparam logic [18:0] DIV3_LO_K = 19'd349526;

   function automatic logic signed [31:0] quarter_sine(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:  v = 32'sd0;
         5'd1:  v = 32'sd1644455;
         5'd2:  v = 32'sd3273072;
         5'd3:  v = 32'sd4870169;
         5'd4:  v = 32'sd6420363;
         5'd5:  v = 32'sd7908725;
         5'd6:  v = 32'sd9320922;
         5'd7:  v = 32'sd10643353;
         5'd8:  v = 32'sd11863283;
         5'd9:  v = 32'sd12968963;
         5'd10: v = 32'sd13949745;
         5'd11: v = 32'sd14796184;
         5'd12: v = 32'sd15500126;
         5'd13: v = 32'sd16054795;
         5'd14: v = 32'sd16454846;
         5'd15: v = 32'sd16696429;
         default: v = 32'sd16777216;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // Floor shift of product equals floor rounding toward minus infinity.
   function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
      logic signed [65:0] q;
      q = 66'(p >>> FRAC_W);
      return sat32(q);
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return sat32(66'(a) + 66'(b));
   endfunction

   // Divide by six, first half: halve the magnitude, divide its upper digit by three.
   // Packs sign, upper quotient, remainder and lower digit from the top bit down.
   function automatic logic [34:0] div6_head(input logic signed [34:0] v);
      logic [34:0] m;
      logic [16:0] th;
      logic [34:0] ph;
      logic [15:0] qh;
      logic [16:0] rh;
      m = v[34] ? 35'(-v) : 35'(v);
      th = m[33:17];
      ph = 35'(th) * 35'(DIV3_HI_K);
      qh = ph[34:19];
      rh = th - 17'(qh) * 17'd3;
      return {v[34], qh, rh[1:0], m[16:1]};
   endfunction

   // Divide by six, second half: lower digit by three, sign restored, toward zero.
   function automatic logic signed [31:0] div6_tail(input logic [34:0] hd);
      logic [17:0] low;
      logic [36:0] pl;
      logic [32:0] q;
      logic signed [32:0] r;
      low = hd[17:0];
      pl = 37'(low) * 37'(DIV3_LO_K);
      q = {1'b0, hd[33:18], pl[35:20]};
      r = hd[34] ? -$signed(q) : $signed(q);
      return sat32(66'(r));
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/delayed_ikeda_reservoir_step.sv
// Top level: delayed Ikeda reservoir of NUM_LANES lanes (four by default), Euler or RK4 step per transaction.
// Lanes go one after another through one shared datapath, and a new transaction is
//    taken only once every lane of the last one is written back.
// The next transaction is taken while a result waits, and a waiting result holds only
//    the last lane's write-back.
// Reset sets the configuration to its defaults and clears the control and lane state, then
//    a clearing pass zeroes the delay memory; no transaction is accepted during the pass.
`default_nettype none
module delayed_ikeda_reservoir_step #(
   parameter int unsigned NUM_LANES   = 4,
   parameter int unsigned DELAY_DEPTH = 512
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [NUM_LANES*32-1:0] req_tdata,  // drive_0, drive_1, ... from bit 0
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [NUM_LANES*32-1:0]      rsp_tdata,  // node_0, node_1, ... from bit 0
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [dikeda_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]             csr_data
);
   import dikeda_pkg::*;

   localparam int unsigned LANE_W = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
   localparam int unsigned PTR_W  = $clog2(DELAY_DEPTH);
   localparam int unsigned LEN_W  = $clog2(DELAY_DEPTH + 1);
   localparam int unsigned ADDR_W = LANE_W + PTR_W;
   localparam int unsigned MEM_D  = NUM_LANES << PTR_W;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_LOAD, S_RDWAIT,
      S_ARG, S_ANG, S_TURN, S_SIN, S_SQ, S_FE, S_DY, S_DER,
      S_HB, S_HX, S_UPD, S_SUM, S_DIVB, S_DIVQ, S_DIVY, S_FIN, S_WR, S_NEXT, S_OUT
   } state_type;

   // configuration
   logic [30:0] step_size_ff;
   logic signed [31:0] gain_ff, damp_ff, phase_ff, dscale_ff;
   logic [9:0] dlen_ff;
   logic mode_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= 31'd16777;
         gain_ff      <= 32'sd16777216;
         damp_ff      <= 32'sd167772;
         phase_ff     <= 32'sd21082871;
         dscale_ff    <= 32'sd16777216;
         dlen_ff      <= 10'd512;
         mode_ff      <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STEP_SIZE:     step_size_ff <= csr_data[30:0];
            CSR_FEEDBACK_GAIN: gain_ff      <= csr_data;
            CSR_DAMPING:       damp_ff      <= csr_data;
            CSR_PHASE_OFFSET:  phase_ff     <= csr_data;
            CSR_DRIVE_SCALING: dscale_ff    <= csr_data;
            CSR_DELAY_LENGTH:  dlen_ff      <= csr_data[9:0];
            CSR_MODE:          mode_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // delay memory
   logic signed [31:0] mem [MEM_D];
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic mem_we;
   logic signed [31:0] mem_wdata, mem_rdata_ff;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   state_type state_ff;
   logic [ADDR_W:0] clr_ff;
   logic [LANE_W-1:0] lane_ff;
   logic [PTR_W-1:0] ptr_ff;
   logic [1:0] stage_ff;
   logic signed [31:0] nodes_ff [NUM_LANES];
   logic signed [31:0] auxs_ff [NUM_LANES];
   logic [NUM_LANES*32-1:0] drv_ff;
   logic signed [31:0] a_ff, ay_ff, x_ff, y_ff, d_ff, drive_ff, k_ff;
   logic signed [31:0] arg_ff, fe_ff, hb_ff, hx_ff;
   logic signed [63:0] prod_ff;
   logic [31:0] ph_ff;
   logic signed [31:0] s_ff, ssq_ff;
   logic signed [34:0] sb_ff, sy_ff;
   logic [34:0] dvb_ff, dvy_ff;
   logic signed [31:0] qb_ff, qy_ff;
   logic outv_ff;
   logic [NUM_LANES*32-1:0] out_ff;

   logic signed [31:0] h_s;
   assign h_s = {1'b0, step_size_ff};

   // sine magnitude from turn phase
   logic [30:0] posm_w;
   logic [4:0] sidx_w;
   logic [15:0] sfrac_w;
   logic signed [31:0] slo_w, shi_w;
   logic signed [49:0] sdel_w;
   always_comb begin
      posm_w = ph_ff[30] ? (31'h40000000 - {1'b0, ph_ff[29:0]}) : {1'b0, ph_ff[29:0]};
      sidx_w = posm_w[30:26];
      sfrac_w = posm_w[25:10];
      slo_w = quarter_sine(sidx_w);
      shi_w = quarter_sine(sidx_w + 5'd1);
      sdel_w = 50'(shi_w - slo_w) * $signed({1'b0, sfrac_w});
   end

   logic last_lane, out_load;
   assign last_lane = (lane_ff == LANE_W'(NUM_LANES - 1));
   assign out_load = (state_ff == S_WR) && last_lane && (!outv_ff || rsp_tready);

   logic [LEN_W-1:0] len_w;
   logic [PTR_W:0] ptr_inc;
   always_comb begin
      if (dlen_ff == 10'd0) len_w = LEN_W'(1);
      else if (32'(dlen_ff) > DELAY_DEPTH) len_w = LEN_W'(DELAY_DEPTH);
      else len_w = LEN_W'(dlen_ff);
      ptr_inc = {1'b0, ptr_ff} + 1'b1;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = outv_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      mem_raddr = {lane_ff, ptr_ff};
      mem_we = 1'b0;
      mem_waddr = {lane_ff, ptr_ff};
      mem_wdata = a_ff;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
         mem_waddr = clr_ff[ADDR_W-1:0];
         mem_wdata = '0;
      end else if (state_ff == S_WR) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         lane_ff <= '0;
         ptr_ff <= '0;
         stage_ff <= '0;
         outv_ff <= 1'b0;
         for (int i = 0; i < NUM_LANES; i++) begin
            nodes_ff[i] <= '0;
            auxs_ff[i] <= '0;
         end
      end else begin
         if (out_load) outv_ff <= 1'b1;
         else if (rsp_tready) outv_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (ADDR_W+1)'(MEM_D - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  drv_ff <= req_tdata;
                  lane_ff <= '0;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               a_ff <= nodes_ff[lane_ff];
               ay_ff <= auxs_ff[lane_ff];
               x_ff <= nodes_ff[lane_ff];
               y_ff <= auxs_ff[lane_ff];
               drive_ff <= drv_ff[lane_ff*32 +: 32];
               stage_ff <= '0;
               sb_ff <= '0;
               sy_ff <= '0;
               state_ff <= S_RDWAIT;
            end
            S_RDWAIT: begin
               d_ff <= mem_rdata_ff;
               prod_ff <= 64'(dscale_ff) * 64'(drive_ff);
               state_ff <= S_ARG;
            end
            S_ARG: begin
               arg_ff <= qadd(qadd(d_ff, phase_ff), qscale(prod_ff));
               state_ff <= S_ANG;
            end
            S_ANG: begin
               prod_ff <= 64'(arg_ff) * 64'(TURN_K);
               state_ff <= S_TURN;
            end
            S_TURN: begin
               ph_ff <= prod_ff[47:16];
               state_ff <= S_SIN;
            end
            S_SIN: begin
               s_ff <= (sidx_w >= 5'd16) ? quarter_sine(5'd16)
                                         : slo_w + 32'(sdel_w >>> 16);
               state_ff <= S_SQ;
            end
            S_SQ: begin
               prod_ff <= 64'(s_ff) * 64'(s_ff);
               state_ff <= S_FE;
            end
            S_FE: begin
               ssq_ff <= 32'(prod_ff >>> 24);
               state_ff <= S_DY;
            end
            S_DY: begin
               prod_ff <= 64'(gain_ff) * 64'(ssq_ff);
               state_ff <= S_DER;
            end
            S_DER: begin
               fe_ff <= qscale(prod_ff);
               prod_ff <= 64'(damp_ff) * 64'(y_ff);
               state_ff <= S_HB;
            end
            S_HB: begin
               k_ff <= sat32(-66'(x_ff) - 66'(qscale(prod_ff)) + 66'(fe_ff));
               state_ff <= S_HX;
            end
            S_HX: begin
               if (stage_ff == 2'd0 || stage_ff == 2'd3) begin
                  sb_ff <= sb_ff + 35'(k_ff);
                  sy_ff <= sy_ff + 35'(x_ff);
               end else begin
                  sb_ff <= sb_ff + 35'(k_ff) + 35'(k_ff);
                  sy_ff <= sy_ff + 35'(x_ff) + 35'(x_ff);
               end
               prod_ff <= 64'(h_s) * 64'(k_ff);
               state_ff <= S_UPD;
            end
            S_UPD: begin
               hb_ff <= qscale(prod_ff);
               prod_ff <= 64'(h_s) * 64'(x_ff);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               hx_ff <= qscale(prod_ff);
               if (!mode_ff) begin
                  state_ff <= S_FIN;
               end else if (stage_ff == 2'd3) begin
                  state_ff <= S_DIVB;
               end else begin
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if (stage_ff == 2'd2) begin
                  x_ff <= qadd(a_ff, hb_ff);
                  y_ff <= qadd(ay_ff, qscale(64'(hx_ff) <<< 24));
               end else begin
                  x_ff <= qadd(a_ff, (hb_ff >>> 1));
                  y_ff <= qadd(ay_ff, (hx_ff >>> 1));
               end
               stage_ff <= stage_ff + 1'b1;
               prod_ff <= 64'(dscale_ff) * 64'(drive_ff);
               state_ff <= S_ARG;
            end
            S_DIVB: begin
               dvb_ff <= div6_head(sb_ff);
               dvy_ff <= div6_head(sy_ff);
               state_ff <= S_DIVQ;
            end
            S_DIVQ: begin
               qb_ff <= div6_tail(dvb_ff);
               qy_ff <= div6_tail(dvy_ff);
               state_ff <= S_DIVY;
            end
            S_DIVY: begin
               prod_ff <= 64'(h_s) * 64'(qb_ff);
               hx_ff <= qy_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               hb_ff <= qscale(prod_ff);
               prod_ff <= 64'(h_s) * 64'(hx_ff);
               stage_ff <= '0;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (mode_ff) hx_ff <= qscale(prod_ff);
               a_ff <= qadd(a_ff, hb_ff);
               ay_ff <= qadd(ay_ff, mode_ff ? qscale(prod_ff) : hx_ff);
               state_ff <= S_WR;
            end
            S_WR: begin
               nodes_ff[lane_ff] <= a_ff;
               auxs_ff[lane_ff] <= ay_ff;
               if (!last_lane) begin
                  lane_ff <= lane_ff + 1'b1;
                  state_ff <= S_LOAD;
               end else if (out_load) begin
                  for (int i = 0; i < NUM_LANES; i++)
                     out_ff[i*32 +: 32] <= (i == NUM_LANES - 1) ? a_ff : nodes_ff[i];
                  lane_ff <= '0;
                  ptr_ff <= (ptr_inc >= (PTR_W+1)'(len_w)) ? '0 : ptr_inc[PTR_W-1:0];
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/dikeda_checker.sv
// Port checker for the reservoir step, bound to the top level.
`default_nettype none
module dikeda_checker #(
   parameter int unsigned NUM_LANES = 4
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [NUM_LANES*32-1:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tdata))
      else $error("unknown result data");
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready after accept");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity after reset");
endmodule

bind delayed_ikeda_reservoir_step dikeda_checker #(.NUM_LANES(NUM_LANES)) u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire

FILE: sim/delayed_ikeda_reservoir_step_tb.sv
// Self-checking testbench for the delayed Ikeda reservoir step with a bit-exact node predictor.
`timescale 1ns / 100ps
`default_nettype none
module delayed_ikeda_reservoir_step_tb;
   import dikeda_pkg::*;

   localparam int LANES = 4;
   localparam int DEPTH = 512;

   typedef logic signed [31:0] q_type;

   class node_scoreboard;
      logic [30:0] h;
      q_type gain, damp, phase, scale;
      logic [9:0] dlen;
      logic rk;
      q_type xv[LANES];
      q_type yv[LANES];
      q_type ring[LANES][DEPTH];
      int unsigned ptr;
      logic [LANES*32-1:0] pending_nodes[$];
      int errors;
      int checked;

      function new();
         h = 31'd16777; gain = 32'sd16777216; damp = 32'sd167772;
         phase = 32'sd21082871; scale = 32'sd16777216; dlen = 10'd512; rk = 1'b0;
         foreach (xv[i]) begin xv[i] = 0; yv[i] = 0; end
         foreach (ring[i, j]) ring[i][j] = 0;
         ptr = 0; errors = 0; checked = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            CSR_STEP_SIZE:     h = v[30:0];
            CSR_FEEDBACK_GAIN: gain = v;
            CSR_DAMPING:       damp = v;
            CSR_PHASE_OFFSET:  phase = v;
            CSR_DRIVE_SCALING: scale = v;
            CSR_DELAY_LENGTH:  dlen = v[9:0];
            CSR_MODE:          rk = v[0];
            default: ;
         endcase
      endfunction

      function q_type clamp(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return q_type'(v);
      endfunction

      function q_type fx_mul(q_type a, q_type b);
         longint p;
         p = longint'(a) * longint'(b);
         return clamp(p >>> 24);
      endfunction

      function q_type fx_add(q_type a, q_type b);
         return clamp(longint'(a) + longint'(b));
      endfunction

      function q_type fx_half(q_type v);
         return q_type'(longint'(v) >>> 1);
      endfunction

      function longint sine_entry(int i);
         case (i)
            0: return 0;         1: return 1644455;   2: return 3273072;
            3: return 4870169;   4: return 6420363;   5: return 7908725;
            6: return 9320922;   7: return 10643353;  8: return 11863283;
            9: return 12968963;  10: return 13949745; 11: return 14796184;
            12: return 15500126; 13: return 16054795; 14: return 16454846;
            15: return 16696429; default: return 16777216;
         endcase
      endfunction

      function q_type sine_squared(q_type angle);
         logic [63:0] prod;
         logic [31:0] turn, pos;
         int unsigned idx, frac;
         longint s, lo, hi;
         prod = 64'(longint'(angle)) * 64'd2670177;
         turn = prod[47:16];
         pos = {2'b00, turn[29:0]};
         if (turn[30]) pos = 32'h40000000 - pos;
         idx = pos >> 26;
         frac = (pos >> 10) & 32'hffff;
         if (idx >= 16) s = sine_entry(16);
         else begin
            lo = sine_entry(idx);
            hi = sine_entry(idx + 1);
            s = lo + (((hi - lo) * longint'(frac)) >>> 16);
         end
         return q_type'((s * s) >>> 24);
      endfunction

      function q_type slope(q_type x, q_type y, q_type d, q_type drv);
         q_type arg, fe;
         arg = fx_add(fx_add(d, phase), fx_mul(scale, drv));
         fe = fx_mul(gain, sine_squared(arg));
         return clamp(-longint'(x) - longint'(fx_mul(damp, y)) + longint'(fe));
      endfunction

      function void note_drive(logic [LANES*32-1:0] drives);
         logic [LANES*32-1:0] nodes;
         int unsigned len, p;
         q_type hs, a, ay, d, drv, x, y;
         q_type xs[4];
         q_type ks[4];
         longint sb, sy;
         hs = q_type'({1'b0, h});
         len = dlen;
         if (len < 1) len = 1;
         if (len > DEPTH) len = DEPTH;
         p = (ptr >= DEPTH) ? 0 : ptr;
         for (int l = 0; l < LANES; l++) begin
            a = xv[l]; ay = yv[l]; drv = drives[l*32 +: 32]; d = ring[l][p];
            if (!rk) begin
               xv[l] = fx_add(a, fx_mul(hs, slope(a, ay, d, drv)));
               yv[l] = fx_add(ay, fx_mul(hs, a));
            end else begin
               x = a; y = ay;
               for (int k = 0; k < 4; k++) begin
                  xs[k] = x;
                  ks[k] = slope(x, y, d, drv);
                  if (k < 2) begin
                     x = fx_add(a, fx_half(fx_mul(hs, ks[k])));
                     y = fx_add(ay, fx_half(fx_mul(hs, xs[k])));
                  end else if (k == 2) begin
                     x = fx_add(a, fx_mul(hs, ks[k]));
                     y = fx_add(ay, fx_mul(hs, xs[k]));
                  end
               end
               sb = longint'(ks[0]) + 2 * longint'(ks[1]) + 2 * longint'(ks[2])
                  + longint'(ks[3]);
               sy = longint'(xs[0]) + 2 * longint'(xs[1]) + 2 * longint'(xs[2])
                  + longint'(xs[3]);
               xv[l] = fx_add(a, fx_mul(hs, clamp(sb / 6)));
               yv[l] = fx_add(ay, fx_mul(hs, clamp(sy / 6)));
            end
            ring[l][p] = xv[l];
            nodes[l*32 +: 32] = xv[l];
         end
         ptr = (p + 1 >= len) ? 0 : p + 1;
         pending_nodes.push_back(nodes);
      endfunction

      function void check_nodes(logic [LANES*32-1:0] got);
         logic [LANES*32-1:0] want;
         if (pending_nodes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_nodes.pop_front();
         checked++;
         for (int l = 0; l < LANES; l++)
            if (got[l*32 +: 32] !== want[l*32 +: 32]) begin
               $display("%0t: node_%0d mismatch, expected %h, actual %h",
                        $time, l, want[l*32 +: 32], got[l*32 +: 32]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [LANES*32-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [LANES*32-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   node_scoreboard nodes_sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;

   delayed_ikeda_reservoir_step #(.NUM_LANES(LANES), .DELAY_DEPTH(DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) nodes_sb.check_nodes(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      nodes_sb.set_reg(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_step(logic [LANES*32-1:0] drives);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= drives;
      do @(posedge clock); while (!req_tready);
      nodes_sb.note_drive(drives);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (nodes_sb.pending_nodes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_q();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(33554432);
         3: return -$urandom_range(33554432);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [LANES*32-1:0] random_drives(bit mild);
      logic [LANES*32-1:0] v;
      for (int l = 0; l < LANES; l++)
         v[l*32 +: 32] = mild ? 32'($signed($urandom_range(67108864)) - 33554432)
                              : pick_q();
      return v;
   endfunction

   task automatic random_phase(int n, int sidle, int ridle);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      write_reg(CSR_STEP_SIZE, $urandom_range(3) == 0 ? pick_q() & 32'h7fffffff
                                                      : $urandom_range(4194304));
      write_reg(CSR_FEEDBACK_GAIN, $urandom_range(2) == 0 ? pick_q()
                                                          : $urandom_range(50331648));
      write_reg(CSR_DAMPING, $urandom_range(2) == 0 ? pick_q() : $urandom_range(4194304));
      write_reg(CSR_PHASE_OFFSET, pick_q());
      write_reg(CSR_DRIVE_SCALING, pick_q());
      write_reg(CSR_DELAY_LENGTH, $urandom_range(3) == 0 ? $urandom_range(1023)
                                                         : $urandom_range(1, 12));
      write_reg(CSR_MODE, $urandom_range(1));
      for (int i = 0; i < n; i++) send_step(random_drives($urandom_range(3) != 0));
      drain();
   endtask

   initial begin
      #1000000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // defaults first, then extremes of every field
      send_step('0);
      send_step({LANES{32'h7fffffff}});
      send_step({LANES{32'h80000000}});
      send_step({32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000001});
      drain();
      write_reg(CSR_DELAY_LENGTH, 32'd0);
      write_reg(CSR_MODE, 32'd1);
      write_reg(CSR_STEP_SIZE, 32'h7fffffff);
      send_step({LANES{32'h01000000}});
      send_step({LANES{32'hff000000}});
      drain();
      write_reg(CSR_DELAY_LENGTH, 32'd1023);
      write_reg(CSR_FEEDBACK_GAIN, 32'h80000000);
      write_reg(CSR_DAMPING, 32'h7fffffff);
      write_reg(CSR_PHASE_OFFSET, 32'h80000000);
      write_reg(CSR_DRIVE_SCALING, 32'h7fffffff);
      for (int i = 0; i < 4; i++) send_step(random_drives(0));
      drain();
      write_reg(CSR_STEP_SIZE, 32'd0);
      write_reg(CSR_MODE, 32'd0);
      write_reg(CSR_FEEDBACK_GAIN, 32'h7fffffff);
      write_reg(CSR_DAMPING, 32'h80000000);
      write_reg(CSR_PHASE_OFFSET, 32'h7fffffff);
      write_reg(CSR_DRIVE_SCALING, 32'h80000000);
      send_step({LANES{32'h55555555}});
      send_step({LANES{32'haaaaaaaa}});
      drain();
      // shrink the ring while the pointer sits beyond the new length
      write_reg(CSR_STEP_SIZE, 32'd1048576);
      write_reg(CSR_DELAY_LENGTH, 32'd3);
      for (int i = 0; i < 4; i++) send_step(random_drives(1));
      drain();
      for (int ph = 0; ph < 15; ph++)
         random_phase(36, ph < 5 ? 21 : (ph < 10 ? 62 : 0),
                          ph < 5 ? 62 : (ph < 10 ? 21 : 0));
      $display("Covered %0d steps and %0d checked node results over Euler and RK4",
               items_sent, nodes_sb.checked);
      $display("with ring lengths from 0 to 1023 and extreme coefficients.");
      if (nodes_sb.errors == 0 && nodes_sb.pending_nodes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
